// ----- sv/isen_pkg.sv -----
// Shared types, widths and codes for the integrator step error norm block.
// No dependencies; imported by every module of the block.
package isen_pkg;

  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 24;
  localparam int NCOMP     = 3;
  localparam int IN_W      = 3 * NCOMP * WORD_BITS;

  localparam int MAG_W = WORD_BITS + 1;          // |new +/- start|
  localparam int LO_W  = (MAG_W + 1) / 2;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int PP_W  = 2 * LO_W;

  localparam int D1_W  = WORD_BITS + 2;          // sum |d|
  localparam int M1_W  = WORD_BITS + 3;          // sum |m|
  localparam int SQ_W  = 2 * WORD_BITS;          // sum d^2
  localparam int M2_W  = 2 * WORD_BITS + 2;      // sum m^2

  localparam int QW    = SQ_W;                   // quotient bits kept
  localparam int NUM_W = SQ_W + 2 * FRAC_BITS + 2;
  localparam int NHI_W = NUM_W - QW;

  localparam int RT_W  = WORD_BITS;              // root bits
  localparam int RR_W  = WORD_BITS + 2;          // root remainder
  localparam int RS_W  = WORD_BITS + 4;

  localparam int CNT_W = $clog2(QW + 1);
  localparam int NOPS  = 2 * NCOMP;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  localparam logic [2:0] MODE_L2_MID  = 3'd0;
  localparam logic [2:0] MODE_L1_MID  = 3'd1;
  localparam logic [2:0] MODE_NONE    = 3'd2;
  localparam logic [2:0] MODE_L1_STEP = 3'd3;
  localparam logic [2:0] MODE_L2_STEP = 3'd4;

  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DRAIN, S_SETUP, S_DIV, S_DIVEND, S_SQRT, S_UPD
  } state_t;

  typedef enum logic [2:0] {
    C_NONE, C_LOAD, C_MUL, C_SETUP, C_DIV, C_DIVEND, C_SQRT, C_UPD
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] opnd;
    logic [1:0] pp;
  } cmd_t;

  typedef struct packed {
    logic use_div;
    logic l2;
    logic last;
  } stat_t;

endpackage

// ----- sv/isen_dp.sv -----
// Datapath: magnitudes, partial-product squaring, restoring divider,
// digit-by-digit square root, running maximum. Depends on isen_pkg.
module isen_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  isen_pkg::cmd_t                          cmd,
  output isen_pkg::stat_t                         stat,
  input  logic [isen_pkg::IN_W-1:0]               in_data,
  input  logic                                    in_last,
  input  logic                                    cfg_we,
  input  logic [isen_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [isen_pkg::WORD_BITS-1:0]          cfg_wdata,
  output logic [isen_pkg::WORD_BITS-1:0]          out_data
);
  import isen_pkg::*;

  logic [2:0]           mode_r;
  logic [WORD_BITS-1:0] thr_r;
  logic [2:0]           mode_eff;
  logic                 mid, l2, none;

  logic [WORD_BITS-1:0] ad_r [NCOMP];
  logic [MAG_W-1:0]     am_r [NCOMP];
  logic [WORD_BITS-1:0] ad_nxt [NCOMP];
  logic [MAG_W-1:0]     am_nxt [NCOMP];
  logic [D1_W-1:0]      d1_r, d1_nxt;
  logic [M1_W-1:0]      m1_r, m1_nxt;
  logic [SQ_W-1:0]      d2_r;
  logic [M2_W-1:0]      m2_r;
  logic                 last_r;

  logic [MAG_W-1:0]     opv;
  logic [LO_W-1:0]      mul_a, mul_b;
  logic [PP_W-1:0]      prod_r;
  logic [1:0]           ppsel_r;
  logic                 tgt_r, pv_r;
  logic [M2_W-1:0]      addend;

  logic [M2_W-1:0]      thr2;
  logic [M1_W-1:0]      thr1;
  logic [NUM_W-1:0]     num;
  logic [M2_W-1:0]      den_r, rem_r, nhi_ext;
  logic [QW-1:0]        numlo_r, q_r;
  logic                 ovf_r;
  logic [M2_W:0]        dsh;
  logic                 dge;

  logic [QW-1:0]        sq_src_r;
  logic [RR_W-1:0]      srem_r;
  logic [RT_W-1:0]      root_r;
  logic [RS_W-1:0]      rs, trial;
  logic                 sge;

  logic [WORD_BITS-1:0] err_r, eff_err, mx, max_r, out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_L2_MID;
      thr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORM_MODE: mode_r <= cfg_wdata[2:0];
        REG_THRESHOLD: thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_eff = (mode_r > MODE_L2_STEP) ? MODE_L2_STEP : mode_r;
    mid  = (mode_eff == MODE_L2_MID) || (mode_eff == MODE_L1_MID);
    l2   = (mode_eff == MODE_L2_MID) || (mode_eff == MODE_L2_STEP);
    none = (mode_eff == MODE_NONE);
  end

  // magnitudes of the incoming group
  always_comb begin
    logic signed [WORD_BITS:0]   dx;
    logic signed [WORD_BITS+1:0] sm;
    d1_nxt = '0;
    m1_nxt = '0;
    for (int i = 0; i < NCOMP; i++) begin
      dx = {in_data[(i+1)*WORD_BITS-1], in_data[i*WORD_BITS +: WORD_BITS]};
      if (dx < 0) dx = -dx;
      ad_nxt[i] = dx[WORD_BITS-1:0];
      if (mid)
        sm = {{2{in_data[(NCOMP+i+1)*WORD_BITS-1]}},
              in_data[(NCOMP+i)*WORD_BITS +: WORD_BITS]}
           + {{2{in_data[(2*NCOMP+i+1)*WORD_BITS-1]}},
              in_data[(2*NCOMP+i)*WORD_BITS +: WORD_BITS]};
      else
        sm = {{2{in_data[(NCOMP+i+1)*WORD_BITS-1]}},
              in_data[(NCOMP+i)*WORD_BITS +: WORD_BITS]}
           - {{2{in_data[(2*NCOMP+i+1)*WORD_BITS-1]}},
              in_data[(2*NCOMP+i)*WORD_BITS +: WORD_BITS]};
      if (sm < 0) sm = -sm;
      am_nxt[i] = sm[MAG_W-1:0];
      d1_nxt = d1_nxt + D1_W'(ad_nxt[i]);
      m1_nxt = m1_nxt + M1_W'(am_nxt[i]);
    end
  end

  // squaring operand and partial product select
  always_comb begin
    if (cmd.opnd < 3'(NCOMP))
      opv = MAG_W'(ad_r[cmd.opnd[1:0]]);
    else
      opv = am_r[2'(cmd.opnd - 3'(NCOMP))];
    mul_a = (cmd.pp == PP_HH) ? LO_W'(opv[MAG_W-1:LO_W]) : opv[LO_W-1:0];
    mul_b = (cmd.pp == PP_LL) ? opv[LO_W-1:0] : LO_W'(opv[MAG_W-1:LO_W]);
    case (ppsel_r)
      PP_LL:   addend = M2_W'(prod_r);
      PP_LH:   addend = M2_W'(prod_r) << (LO_W + 1);
      default: addend = M2_W'(prod_r) << (2 * LO_W);
    endcase
  end

  // thresholds and divider operands
  always_comb begin
    thr2 = mid ? (M2_W'(thr_r) << (FRAC_BITS + 2)) : (M2_W'(thr_r) << FRAC_BITS);
    thr1 = mid ? (M1_W'(thr_r) << 1) : M1_W'(thr_r);
    if (l2)
      num = mid ? (NUM_W'(d2_r) << (2 * FRAC_BITS + 2))
                : (NUM_W'(d2_r) << (2 * FRAC_BITS));
    else
      num = mid ? (NUM_W'(d1_r) << (FRAC_BITS + 1)) : (NUM_W'(d1_r) << FRAC_BITS);
    nhi_ext = M2_W'(num[NUM_W-1:QW]);
    stat.use_div = !none && (l2 ? (m2_r > thr2) : (m1_r > thr1));
    stat.l2      = l2;
    stat.last    = last_r;
  end

  always_comb begin
    dsh   = {rem_r, numlo_r[QW-1]};
    dge   = dsh >= {1'b0, den_r};
    rs    = {srem_r, sq_src_r[QW-1:QW-2]};
    trial = RS_W'({root_r, 2'b01});
    sge   = rs >= trial;
    eff_err = l2 ? root_r : err_r;
    mx      = (eff_err > max_r) ? eff_err : max_r;
  end

  always_ff @(posedge clk) begin
    pv_r <= (cmd.op == C_MUL);
    if (pv_r) begin
      if (tgt_r) m2_r <= m2_r + addend;
      else       d2_r <= d2_r + addend[SQ_W-1:0];
    end
    unique case (cmd.op)
      C_LOAD: begin
        ad_r   <= ad_nxt;
        am_r   <= am_nxt;
        d1_r   <= d1_nxt;
        m1_r   <= m1_nxt;
        d2_r   <= '0;
        m2_r   <= '0;
        last_r <= in_last;
      end
      C_MUL: begin
        prod_r  <= PP_W'(mul_a) * PP_W'(mul_b);
        ppsel_r <= cmd.pp;
        tgt_r   <= cmd.opnd >= 3'(NCOMP);
      end
      C_SETUP: begin
        den_r    <= l2 ? m2_r : M2_W'(m1_r);
        ovf_r    <= nhi_ext >= (l2 ? m2_r : M2_W'(m1_r));
        rem_r    <= nhi_ext;
        numlo_r  <= num[QW-1:0];
        q_r      <= '0;
        sq_src_r <= d2_r;
        srem_r   <= '0;
        root_r   <= '0;
        if (none)                          err_r <= '0;
        else if (|d1_r[D1_W-1:WORD_BITS])  err_r <= '1;
        else                               err_r <= d1_r[WORD_BITS-1:0];
      end
      C_DIV: begin
        rem_r   <= dge ? M2_W'(dsh - {1'b0, den_r}) : dsh[M2_W-1:0];
        q_r     <= {q_r[QW-2:0], dge};
        numlo_r <= numlo_r << 1;
      end
      C_DIVEND: begin
        sq_src_r <= ovf_r ? '1 : q_r;
        srem_r   <= '0;
        root_r   <= '0;
        if (ovf_r || (|q_r[QW-1:WORD_BITS])) err_r <= '1;
        else                                 err_r <= q_r[WORD_BITS-1:0];
      end
      C_SQRT: begin
        srem_r   <= sge ? RR_W'(rs - trial) : rs[RR_W-1:0];
        root_r   <= {root_r[RT_W-2:0], sge};
        sq_src_r <= sq_src_r << 2;
      end
      C_UPD: if (last_r) out_r <= mx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      max_r <= '0;
    else if (cmd.op == C_UPD)
      max_r <= last_r ? '0 : mx;
  end

  assign out_data = out_r;

endmodule

// ----- sv/isen_ctrl.sv -----
// Controller: sequences load, squaring, divide, square root and result.
// Depends on isen_pkg.
module isen_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output isen_pkg::cmd_t  cmd,
  input  isen_pkg::stat_t stat
);
  import isen_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       opnd_r, opnd_nxt;
  logic [1:0]       pp_r, pp_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             upd_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      opnd_r      <= '0;
      pp_r        <= PP_LL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      opnd_r      <= opnd_nxt;
      pp_r        <= pp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    opnd_nxt  = opnd_r;
    pp_nxt    = pp_r;
    cmd.op    = C_NONE;
    cmd.opnd  = opnd_r;
    cmd.pp    = pp_r;
    in_tready = 1'b0;
    upd_fire  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = C_LOAD;
          opnd_nxt  = '0;
          pp_nxt    = PP_LL;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = C_MUL;
        if (pp_r == PP_HH) begin
          pp_nxt   = PP_LL;
          opnd_nxt = opnd_r + 3'd1;
          if (opnd_r == 3'(NOPS - 1)) state_nxt = S_DRAIN;
        end else begin
          pp_nxt = pp_r + 2'd1;
        end
      end
      S_DRAIN: state_nxt = S_SETUP;
      S_SETUP: begin
        cmd.op  = C_SETUP;
        cnt_nxt = '0;
        if (stat.use_div) state_nxt = S_DIV;
        else if (stat.l2) state_nxt = S_SQRT;
        else              state_nxt = S_UPD;
      end
      S_DIV: begin
        cmd.op  = C_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QW - 1)) state_nxt = S_DIVEND;
      end
      S_DIVEND: begin
        cmd.op    = C_DIVEND;
        cnt_nxt   = '0;
        state_nxt = stat.l2 ? S_SQRT : S_UPD;
      end
      S_SQRT: begin
        cmd.op  = C_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RT_W - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!stat.last || !out_valid_r || out_tready) begin
          cmd.op    = C_UPD;
          upd_fire  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || (upd_fire && stat.last);
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/integrator_step_error_norm.sv -----
// Top level of the integrator step error norm block.
// Depends on isen_pkg, isen_ctrl and isen_dp.
//
// One request (a three-component group) is squared on a shared 25x25
// multiplier (18 partial products, then a drain state), then goes through
// either a restoring divide, a square root, both, or neither, between the
// accept, set-up and update states; the divider loop is the longest part.
// No new request is taken before the update of the one in flight. The
// next request is taken while a finished result waits on the output; a
// last request holds in its update cycle while an earlier result is still
// waiting.
module integrator_step_error_norm (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // diff_x, diff_y, diff_z, new_x, new_y, new_z, start_x, start_y, start_z
  input  logic [isen_pkg::IN_W-1:0]                in_tdata,
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // max_error
  output logic [isen_pkg::WORD_BITS-1:0]           out_tdata,
  input  logic                                     cfg_we,
  input  logic [isen_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [isen_pkg::WORD_BITS-1:0]           cfg_wdata
);
  import isen_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  isen_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  isen_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule

// ----- sv/isen_chk.sv -----
// Port-level checks for the integrator step error norm block, with bind.
// Depends on integrator_step_error_norm.
module isen_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before taken");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_busy_squaring: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##16 !in_tready)
    else $error("group finished too early");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind integrator_step_error_norm isen_chk u_isen_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
